@@ hw/rtl/scc_pkg.sv @@
package scc_pkg;

    // Width and depth constants shared by the converter and its CORDIC units.
    localparam int TABLE_LEN      = 40;
    localparam int SQRT_STEPS     = 32;
    localparam int IN_DELAY       = SQRT_STEPS + 3;
    localparam int ROT_W          = 34;
    localparam int VEC_W          = 59;
    localparam int ANG_W          = 34;
    localparam int PRESCALE_SHIFT = 24;

    localparam logic [31:0] KINV_Q30     = 32'h26DD3B6A;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Request codes.
    localparam logic REQ_TO_CART = 1'b0;
    localparam logic REQ_TO_SPH  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [31:0] radius;
        logic        [31:0] polar;
        logic        [31:0] azimuth;
    } item_t;

    typedef struct packed {
        logic        req_type;
        logic        pole;
        logic        z_neg;
        logic [31:0] radius;
        logic [31:0] r_in;
    } side_t;

    // atan(2^-i) as a binary angle, 2^32 = one turn.
    function automatic logic [31:0] atan_angle(input int unsigned idx);
        logic [31:0] val;
        unique case (idx)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            24:      val = 32'h00000029;
            25:      val = 32'h00000014;
            26:      val = 32'h0000000A;
            27:      val = 32'h00000005;
            28:      val = 32'h00000003;
            29:      val = 32'h00000001;
            30:      val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/spherical_cartesian_converter.sv @@
// Spherical / cartesian coordinate converter.
// The input channel (in_valid, in_stall) carries one request per transfer; req_type
// selects spherical to cartesian (in_radius, in_polar, in_azimuth used) or cartesian
// to spherical (in_x, in_y, in_z used). The output channel (out_valid, out_stall)
// returns exactly one result per request, in order. Fields of the conversion that
// was not asked for read as zero.
// Throughput is one transfer per cycle unless a result is held; latency is equal for
// both request types; it is set by the 32-step square-root pipeline feeding the
// polar-angle CORDIC, followed by two multiply stages and the output register.
// The whole pipeline advances as one: while out_valid is high and out_stall is
// high every stage holds and in_stall is raised, so nothing is lost or repeated.
// Reset clears the valid bits of every stage; data registers are not reset.
module spherical_cartesian_converter #(
    parameter int CORDIC_STAGES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic        [31:0] in_radius,
    input  logic        [31:0] in_polar,
    input  logic        [31:0] in_azimuth,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic        [31:0] out_radius,
    output logic        [31:0] out_polar,
    output logic        [31:0] out_azimuth,
    output logic               saturated
);

    localparam int N        = CORDIC_STAGES;
    localparam int LAT      = N + 40;
    localparam int SQ_STEPS = scc_pkg::SQRT_STEPS;
    localparam int DLY      = scc_pkg::IN_DELAY;
    localparam int AW       = scc_pkg::ANG_W;
    localparam logic signed [AW-1:0] ANG_HALF = {{(AW-32){1'b0}}, scc_pkg::HALF_TURN};
    localparam logic signed [64:0] RND65 = 65'sd536870912;
    localparam logic signed [66:0] RND67 = 67'sd536870912;

    // Pipeline control: every register moves on en; valid bits ride along.
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en        = !vld_reg[LAT-1] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Request delay line: holds each request until its radius and rho are ready.
    scc_pkg::item_t in_item;
    scc_pkg::item_t item_dly_reg [0:DLY-1];
    scc_pkg::item_t dly_item;

    always_comb
    begin
        in_item.req_type = req_type;
        in_item.x        = in_x;
        in_item.y        = in_y;
        in_item.z        = in_z;
        in_item.radius   = in_radius;
        in_item.polar    = in_polar;
        in_item.azimuth  = in_azimuth;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_dly_reg[0] <= in_item;
            for (int k = 1; k < DLY; k++)
                item_dly_reg[k] <= item_dly_reg[k-1];
        end
    end

    assign dly_item = item_dly_reg[DLY-1];

    // Squares of the cartesian inputs.
    logic [63:0] xx_reg;
    logic [63:0] yy_reg;
    logic [63:0] zz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= in_x * in_x;
            yy_reg <= in_y * in_y;
            zz_reg <= in_z * in_z;
        end
    end

    // Two square-root pipelines, one result bit per stage, then rounding to nearest.
    logic [63:0] rem_xy_reg  [0:SQ_STEPS];
    logic [63:0] res_xy_reg  [0:SQ_STEPS];
    logic [63:0] rem_all_reg [0:SQ_STEPS];
    logic [63:0] res_all_reg [0:SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_xy_reg[0]  <= xx_reg + yy_reg;
            res_xy_reg[0]  <= '0;
            rem_all_reg[0] <= xx_reg + yy_reg + zz_reg;
            res_all_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] t_xy;
        logic [63:0] t_all;

        assign t_xy  = res_xy_reg[k] + BIT;
        assign t_all = res_all_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_xy_reg[k] >= t_xy)
                begin
                    rem_xy_reg[k+1] <= rem_xy_reg[k] - t_xy;
                    res_xy_reg[k+1] <= (res_xy_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rem_xy_reg[k+1] <= rem_xy_reg[k];
                    res_xy_reg[k+1] <= res_xy_reg[k] >> 1;
                end
                if (rem_all_reg[k] >= t_all)
                begin
                    rem_all_reg[k+1] <= rem_all_reg[k] - t_all;
                    res_all_reg[k+1] <= (res_all_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rem_all_reg[k+1] <= rem_all_reg[k];
                    res_all_reg[k+1] <= res_all_reg[k] >> 1;
                end
            end
        end
    end

    logic [32:0] rho_reg;
    logic [31:0] rad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rho_reg <= res_xy_reg[SQ_STEPS][32:0]
                     + 33'(rem_xy_reg[SQ_STEPS] > res_xy_reg[SQ_STEPS]);
            rad_reg <= res_all_reg[SQ_STEPS][31:0]
                     + 32'(rem_all_reg[SQ_STEPS] > res_all_reg[SQ_STEPS]);
        end
    end

    // CORDIC units, all launched from the same stage.
    logic signed [31:0]   cp;
    logic signed [31:0]   sp;
    logic signed [31:0]   ca;
    logic signed [31:0]   sa;
    logic signed [AW-1:0] ang_p;
    logic signed [AW-1:0] ang_a;
    logic signed [33:0]   vp_px;
    logic signed [33:0]   vp_py;
    logic signed [33:0]   va_px;
    logic signed [33:0]   va_py;

    assign vp_px = {{2{dly_item.z[31]}}, dly_item.z};
    assign vp_py = {1'b0, rho_reg};
    assign va_px = {{2{dly_item.x[31]}}, dly_item.x};
    assign va_py = {{2{dly_item.y[31]}}, dly_item.y};

    scc_rot #(.STAGES(N)) u_rot_polar (
        .clk     (clk),
        .en      (en),
        .angle   (dly_item.polar),
        .cos_val (cp),
        .sin_val (sp)
    );

    scc_rot #(.STAGES(N)) u_rot_azimuth (
        .clk     (clk),
        .en      (en),
        .angle   (dly_item.azimuth),
        .cos_val (ca),
        .sin_val (sa)
    );

    scc_vec #(.STAGES(N)) u_vec_polar (
        .clk   (clk),
        .en    (en),
        .px    (vp_px),
        .py    (vp_py),
        .angle (ang_p)
    );

    scc_vec #(.STAGES(N)) u_vec_azimuth (
        .clk   (clk),
        .en    (en),
        .px    (va_px),
        .py    (va_py),
        .angle (ang_a)
    );

    // Side information that travels beside the CORDIC units.
    scc_pkg::side_t side_reg [0:N+1];
    scc_pkg::side_t side_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].req_type <= dly_item.req_type;
            side_reg[0].pole     <= (dly_item.x == '0) && (dly_item.y == '0);
            side_reg[0].z_neg    <= dly_item.z[31];
            side_reg[0].radius   <= rad_reg;
            side_reg[0].r_in     <= dly_item.radius;
            for (int k = 1; k <= N + 1; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign side_out = side_reg[N+1];

    // First multiply stage: r * sin(polar) and r * cos(polar); angle clean-up.
    logic signed [32:0] r_s;
    logic signed [64:0] p_sq;
    logic signed [64:0] p_zq;
    logic signed [64:0] p_sq_rnd;
    logic signed [64:0] p_zq_rnd;
    logic        [31:0] pol_next;
    logic        [31:0] az_next;

    logic signed [34:0] sq_reg;
    logic signed [34:0] zq_a_reg;
    logic signed [31:0] ca_reg;
    logic signed [31:0] sa_reg;
    logic               mode_a_reg;
    logic        [31:0] rad_a_reg;
    logic        [31:0] pol_a_reg;
    logic        [31:0] az_a_reg;

    always_comb
    begin
        r_s      = {1'b0, side_out.r_in};
        p_sq     = r_s * sp;
        p_zq     = r_s * cp;
        p_sq_rnd = p_sq + RND65;
        p_zq_rnd = p_zq + RND65;
        if (side_out.pole)
        begin
            pol_next = side_out.z_neg ? scc_pkg::HALF_TURN : '0;
            az_next  = '0;
        end
        else
        begin
            if (ang_p[AW-1])
                pol_next = '0;
            else if (ang_p > ANG_HALF)
                pol_next = scc_pkg::HALF_TURN;
            else
                pol_next = ang_p[31:0];
            az_next = ang_a[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= p_sq_rnd[64:30];
            zq_a_reg   <= p_zq_rnd[64:30];
            ca_reg     <= ca;
            sa_reg     <= sa;
            mode_a_reg <= side_out.req_type;
            rad_a_reg  <= side_out.radius;
            pol_a_reg  <= pol_next;
            az_a_reg   <= az_next;
        end
    end

    // Second multiply stage: times cos(azimuth) and sin(azimuth).
    logic signed [66:0] p_x;
    logic signed [66:0] p_y;
    logic signed [66:0] p_x_rnd;
    logic signed [66:0] p_y_rnd;

    logic signed [36:0] xq_reg;
    logic signed [36:0] yq_reg;
    logic signed [34:0] zq_b_reg;
    logic               mode_b_reg;
    logic        [31:0] rad_b_reg;
    logic        [31:0] pol_b_reg;
    logic        [31:0] az_b_reg;

    always_comb
    begin
        p_x     = sq_reg * ca_reg;
        p_y     = sq_reg * sa_reg;
        p_x_rnd = p_x + RND67;
        p_y_rnd = p_y + RND67;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xq_reg     <= p_x_rnd[66:30];
            yq_reg     <= p_y_rnd[66:30];
            zq_b_reg   <= zq_a_reg;
            mode_b_reg <= mode_a_reg;
            rad_b_reg  <= rad_a_reg;
            pol_b_reg  <= pol_a_reg;
            az_b_reg   <= az_a_reg;
        end
    end

    // Output stage: saturate the cartesian results and zero the unused fields.
    function automatic logic [32:0] sat32(input logic signed [36:0] v);
        logic [32:0] res;
        if (v > 37'sd2147483647)
            res = {1'b1, 32'h7FFF_FFFF};
        else if (v < -37'sd2147483648)
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b0, v[31:0]};
        return res;
    endfunction

    logic [32:0] sx;
    logic [32:0] sy;
    logic [32:0] sz;

    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic        [31:0] out_radius_reg;
    logic        [31:0] out_polar_reg;
    logic        [31:0] out_azimuth_reg;
    logic               saturated_reg;

    always_comb
    begin
        sx = sat32(xq_reg);
        sy = sat32(yq_reg);
        sz = sat32(37'(zq_b_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (mode_b_reg == scc_pkg::REQ_TO_SPH)
            begin
                out_x_reg       <= '0;
                out_y_reg       <= '0;
                out_z_reg       <= '0;
                saturated_reg   <= 1'b0;
                out_radius_reg  <= rad_b_reg;
                out_polar_reg   <= pol_b_reg;
                out_azimuth_reg <= az_b_reg;
            end
            else
            begin
                out_x_reg       <= sx[31:0];
                out_y_reg       <= sy[31:0];
                out_z_reg       <= sz[31:0];
                saturated_reg   <= sx[32] | sy[32] | sz[32];
                out_radius_reg  <= '0;
                out_polar_reg   <= '0;
                out_azimuth_reg <= '0;
            end
        end
    end

    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign out_radius  = out_radius_reg;
    assign out_polar   = out_polar_reg;
    assign out_azimuth = out_azimuth_reg;
    assign saturated   = saturated_reg;

    // A held result freezes the whole pipeline, including the input side.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input accepted while a result is held");

    // A held result does not advance the valid chain.
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (vld_reg == $past(vld_reg)))
        else $error("valid chain moved during a stall");

    // A saturated result only comes from a cartesian request.
    a_sat_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (out_radius == '0 && out_polar == '0 && out_azimuth == '0))
        else $error("saturation flagged on a spherical result");

    // The polar result never exceeds a half turn.
    a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_polar <= scc_pkg::HALF_TURN))
        else $error("polar angle beyond a half turn");

endmodule

@@ hw/rtl/scc_rot.sv @@
// Rotation-mode CORDIC: cosine and sine in Q2.30 of a 32-bit binary angle.
// The input register, the iteration stages and the output register advance on en.
module scc_rot #(
    parameter int STAGES = 32
) (
    input  logic               clk,
    input  logic               en,
    input  logic        [31:0] angle,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    localparam int W = scc_pkg::ROT_W;
    localparam logic signed [W-1:0] POS_ONE = W'(64'sd1073741824);
    localparam logic signed [W-1:0] NEG_ONE = -POS_ONE;

    logic signed [W-1:0] x_reg [0:STAGES];
    logic signed [W-1:0] y_reg [0:STAGES];
    logic signed [W-1:0] z_reg [0:STAGES];
    logic                flip_reg [0:STAGES];

    logic                flip_next;
    logic        [31:0]  start_angle;
    logic signed [W-1:0] xf;
    logic signed [W-1:0] yf;
    logic signed [31:0]  cos_next;
    logic signed [31:0]  sin_next;
    logic signed [31:0]  cos_reg;
    logic signed [31:0]  sin_reg;

    // Angles in the left half plane are turned by a half turn and the result negated.
    always_comb
    begin
        flip_next   = (angle - scc_pkg::QUARTER_TURN) < scc_pkg::HALF_TURN;
        start_angle = flip_next ? angle + scc_pkg::HALF_TURN : angle;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= {{(W-32){1'b0}}, scc_pkg::KINV_Q30};
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(W-32){start_angle[31]}}, start_angle};
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = {{(W-32){1'b0}}, scc_pkg::atan_angle(i)};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_comb
    begin
        xf = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        yf = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        if (xf > POS_ONE)
            cos_next = POS_ONE[31:0];
        else if (xf < NEG_ONE)
            cos_next = NEG_ONE[31:0];
        else
            cos_next = xf[31:0];
        if (yf > POS_ONE)
            sin_next = POS_ONE[31:0];
        else if (yf < NEG_ONE)
            sin_next = NEG_ONE[31:0];
        else
            sin_next = yf[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ hw/rtl/scc_vec.sv @@
// Vectoring-mode CORDIC: signed binary angle of the vector (px, py).
// The input register, the iteration stages and the output register advance on en.
module scc_vec #(
    parameter int STAGES = 32
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [33:0]              px,
    input  logic signed [33:0]              py,
    output logic signed [scc_pkg::ANG_W-1:0] angle
);

    localparam int W  = scc_pkg::VEC_W;
    localparam int AW = scc_pkg::ANG_W;

    logic signed [W-1:0]  px_reg  [0:STAGES];
    logic signed [W-1:0]  py_reg  [0:STAGES];
    logic signed [AW-1:0] ang_reg [0:STAGES];
    logic signed [AW-1:0] angle_reg;

    logic signed [W-1:0]  pxs;
    logic signed [W-1:0]  pys;

    always_comb
    begin
        pxs = W'(px) <<< scc_pkg::PRESCALE_SHIFT;
        pys = W'(py) <<< scc_pkg::PRESCALE_SHIFT;
    end

    // A vector in the left half plane is mirrored through the origin first.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (px[33])
            begin
                px_reg[0]  <= -pxs;
                py_reg[0]  <= -pys;
                ang_reg[0] <= {{(AW-32){1'b0}}, scc_pkg::HALF_TURN};
            end
            else
            begin
                px_reg[0]  <= pxs;
                py_reg[0]  <= pys;
                ang_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [W-1:0]  dx;
        logic signed [W-1:0]  dy;
        logic signed [AW-1:0] da;
        logic                 py_pos;

        assign dx     = py_reg[i] >>> i;
        assign dy     = px_reg[i] >>> i;
        assign da     = {{(AW-32){1'b0}}, scc_pkg::atan_angle(i)};
        assign py_pos = !py_reg[i][W-1] && (py_reg[i] != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (py_pos)
                begin
                    px_reg[i+1]  <= px_reg[i] + dx;
                    py_reg[i+1]  <= py_reg[i] - dy;
                    ang_reg[i+1] <= ang_reg[i] + da;
                end
                else
                begin
                    px_reg[i+1]  <= px_reg[i] - dx;
                    py_reg[i+1]  <= py_reg[i] + dy;
                    ang_reg[i+1] <= ang_reg[i] - da;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= ang_reg[STAGES];
    end

    assign angle = angle_reg;

endmodule

@@ tb/sv/tb_spherical_cartesian_converter.sv @@
module tb_spherical_cartesian_converter;

    timeunit 1ns;
    timeprecision 1ps;

    // The converter has a fixed pipeline of CORDIC_STAGES + 40 stages.
    localparam int STAGES      = 32;
    localparam int LATENCY     = STAGES + 40;
    localparam int WATCH_LIMIT = 40 * LATENCY + 400;
    localparam int NUM_RANDOM  = 880;

    // One conversion result, with every output field.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [31:0] radius;
        logic        [31:0] polar;
        logic        [31:0] azimuth;
        logic               sat;
    } coords_t;

    // The scoreboard computes the expected coordinates of every accepted
    // request and compares the converter's results against them, in order.
    class coord_scoreboard;
        coords_t pending[$];
        int      errors;
        int      checked;
        int      n_cart;
        int      n_sph;
        int      n_sat;
        int      n_pole;

        // Arithmetic shift right of a 64-bit signed value.
        function automatic longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Rounded Q2.30 product: add half, then shift right by 30.
        function automatic longint round_q30(longint p);
            return (p + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function automatic longint sat32(longint v, ref bit flag);
            if (v > 64'sd2147483647)
            begin
                flag = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                flag = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // Rotation CORDIC giving cosine and sine in Q2.30.
        function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
            bit          flip;
            longint      cx;
            longint      sy;
            longint      rem;
            longint      dx;
            longint      dy;
            logic [31:0] a;
            flip = (ang - scc_pkg::QUARTER_TURN) < scc_pkg::HALF_TURN;
            a = flip ? ang + scc_pkg::HALF_TURN : ang;
            cx = longint'(scc_pkg::KINV_Q30);
            sy = 0;
            rem = longint'(signed'(a));
            for (int i = 0; i < STAGES && i < scc_pkg::TABLE_LEN; i++)
            begin
                dx = shr(sy, i);
                dy = shr(cx, i);
                if (rem >= 0)
                begin
                    cx -= dx;
                    sy += dy;
                    rem -= longint'(atan_table(i));
                end
                else
                begin
                    cx += dx;
                    sy -= dy;
                    rem += longint'(atan_table(i));
                end
            end
            if (flip)
            begin
                cx = -cx;
                sy = -sy;
            end
            c = clip(cx, -(64'sd1 <<< 30), 64'sd1 <<< 30);
            s = clip(sy, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        endfunction

        // Own copy of the arctangent table, as binary angles.
        function automatic longint atan_table(int i);
            logic [31:0] t[0:30] = '{
                32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
                32'h00000001};
            return (i <= 30) ? longint'(t[i]) : 0;
        endfunction

        // Vectoring CORDIC: signed angle of (px, py), half turn = 2^31.
        function automatic longint arc_angle(longint py, longint px);
            longint ang;
            longint dx;
            longint dy;
            ang = 0;
            px = px * (64'sd1 <<< 24);
            py = py * (64'sd1 <<< 24);
            if (px < 0)
            begin
                px = -px;
                py = -py;
                ang = 64'sd2147483648;
            end
            for (int i = 0; i < STAGES && i < scc_pkg::TABLE_LEN; i++)
            begin
                dx = shr(py, i);
                dy = shr(px, i);
                if (py > 0)
                begin
                    px += dx;
                    py -= dy;
                    ang += atan_table(i);
                end
                else
                begin
                    px -= dx;
                    py += dy;
                    ang -= atan_table(i);
                end
            end
            return ang;
        endfunction

        // Integer square root, rounded to nearest.
        function automatic longint unsigned root_round(longint unsigned v);
            longint unsigned rem;
            longint unsigned res;
            longint unsigned b;
            rem = v;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (rem >= res + b)
                begin
                    rem -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            if (rem > res)
                res++;
            return res;
        endfunction

        function automatic coords_t convert(scc_pkg::item_t it);
            coords_t         e;
            longint          cp;
            longint          sp;
            longint          ca;
            longint          sa;
            longint          rs;
            longint          r;
            longint          x;
            longint          y;
            longint          z;
            longint          pol;
            longint unsigned sq;
            bit              flag;
            e = '0;
            flag = 1'b0;
            if (it.req_type == scc_pkg::REQ_TO_CART)
            begin
                r = longint'({32'd0, it.radius});
                rotate(it.polar, cp, sp);
                rotate(it.azimuth, ca, sa);
                rs = round_q30(r * sp);
                e.x = 32'(sat32(round_q30(rs * ca), flag));
                e.y = 32'(sat32(round_q30(rs * sa), flag));
                e.z = 32'(sat32(round_q30(r * cp), flag));
                e.sat = flag;
            end
            else
            begin
                x = longint'(it.x);
                y = longint'(it.y);
                z = longint'(it.z);
                sq = longint'(x * x) + longint'(y * y);
                e.radius = 32'(root_round(sq + longint'(z * z)));
                if (x == 0 && y == 0)
                begin
                    e.polar = (z < 0) ? scc_pkg::HALF_TURN : 32'd0;
                    e.azimuth = 32'd0;
                end
                else
                begin
                    pol = clip(arc_angle(longint'(root_round(sq)), z), 0, 64'sd2147483648);
                    e.polar = 32'(pol);
                    e.azimuth = 32'(arc_angle(y, x));
                end
            end
            return e;
        endfunction

        // Called for every accepted request.
        function void note_request(scc_pkg::item_t it);
            coords_t e;
            e = convert(it);
            pending.push_back(e);
            if (it.req_type == scc_pkg::REQ_TO_CART)
            begin
                n_cart++;
                if (e.sat)
                    n_sat++;
            end
            else
            begin
                n_sph++;
                if (it.x == 0 && it.y == 0)
                    n_pole++;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0s at result %0d: got %h expected %h",
                     what, checked, got, want);
        endtask

        // Called for every accepted result.
        task check_result(coords_t got);
            coords_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("unexpected result at result %0d", checked);
                checked++;
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x)             report("out_x", got.x, e.x);
            if (got.y !== e.y)             report("out_y", got.y, e.y);
            if (got.z !== e.z)             report("out_z", got.z, e.z);
            if (got.radius !== e.radius)   report("out_radius", got.radius, e.radius);
            if (got.polar !== e.polar)     report("out_polar", got.polar, e.polar);
            if (got.azimuth !== e.azimuth) report("out_azimuth", got.azimuth, e.azimuth);
            if (got.sat !== e.sat)         report("saturated", {31'd0, got.sat},
                                                  {31'd0, e.sat});
            checked++;
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic        [31:0] in_radius;
    logic        [31:0] in_polar;
    logic        [31:0] in_azimuth;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [31:0] out_radius;
    logic        [31:0] out_polar;
    logic        [31:0] out_azimuth;
    logic               saturated;

    coord_scoreboard sb;
    int              idle_cycles;

    spherical_cartesian_converter #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_z       (in_z),
        .in_radius  (in_radius),
        .in_polar   (in_polar),
        .in_azimuth (in_azimuth),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_radius (out_radius),
        .out_polar  (out_polar),
        .out_azimuth(out_azimuth),
        .saturated  (saturated)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The watchdog counts cycles in which neither channel has a transfer.
    // A hung pipeline therefore ends the run instead of spinning forever.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("FAIL spherical_cartesian_converter");
            $finish;
        end
    end

    // The checker samples the result channel at every rising edge. Since the
    // driver changes out_stall with nonblocking assignments, the value read
    // here is the one that held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{out_x, out_y, out_z, out_radius, out_polar,
                              out_azimuth, saturated});
    end

    // Drives one request and holds it until the converter takes it, after a
    // random number of idle cycles in front of it.
    task automatic send_request(scc_pkg::item_t it);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= it.req_type;
        in_x       <= it.x;
        in_y       <= it.y;
        in_z       <= it.z;
        in_radius  <= it.radius;
        in_polar   <= it.polar;
        in_azimuth <= it.azimuth;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // The transfer happened at this edge; note it for prediction.
        sb.note_request(it);
    endtask

    // Builds a request from explicit fields; unused fields get random noise.
    function automatic scc_pkg::item_t make_request(logic kind, logic [31:0] a,
                                                    logic [31:0] b, logic [31:0] c);
        scc_pkg::item_t it;
        it.req_type = kind;
        it.x        = $urandom;
        it.y        = $urandom;
        it.z        = $urandom;
        it.radius   = $urandom;
        it.polar    = $urandom;
        it.azimuth  = $urandom;
        if (kind == scc_pkg::REQ_TO_CART)
        begin
            it.radius  = a;
            it.polar   = b;
            it.azimuth = c;
        end
        else
        begin
            it.x = a;
            it.y = b;
            it.z = c;
        end
        return it;
    endfunction

    // Random value that often falls on an extreme or a small magnitude.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(0, 32'h0003_FFFF);
            5:       return -$urandom_range(0, 32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // The receiver stalls for a random number of cycles, then accepts, with
    // stretches where it never stalls at all.
    initial
    begin
        int wait_len;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) < 3)
                wait_len = 0;
            else
                wait_len = $urandom_range(0, 16);
            if (wait_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_len)
                    @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            // Keep accepting for a while before the next stall draw.
            repeat ($urandom_range(0, 3))
                @(posedge clk);
        end
    end

    initial
    begin
        scc_pkg::item_t it;
        logic [31:0]    ang_list[8];
        int             settle;
        sb           = new();
        idle_cycles  = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = scc_pkg::REQ_TO_CART;
        in_x         = '0;
        in_y         = '0;
        in_z         = '0;
        in_radius    = '0;
        in_polar     = '0;
        in_azimuth   = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, both conversions, the pole axis
        // with both signs of z, polar angles beyond a half turn, and
        // results large enough to saturate.
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'h0, 32'h0, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'hFFFF_FFFF, 32'h4000_0000,
                                  32'h8000_0000));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_FFFF));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'h0001_0000, 32'hC000_0000,
                                  32'h4000_0000));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'h0001_0000, 32'hFFFF_FFFF,
                                  32'hC000_0000));
        send_request(make_request(scc_pkg::REQ_TO_CART, 32'h8000_0000, 32'h2000_0000,
                                  32'h2000_0000));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0, 32'h0, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0, 32'h0, 32'h0001_0000));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0, 32'h0, 32'hFFFF_0000));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0, 32'h0, 32'h8000_0000));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h8000_0000, 32'h0, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0, 32'hFFFF_FFFF, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'hFFFF_0000, 32'h0, 32'h0));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0001_0000, 32'hFFFF_0000,
                                  32'h0001_0000));
        send_request(make_request(scc_pkg::REQ_TO_SPH, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF));

        // Let the pipeline drain completely before the random part.
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);

        // Random part. Angles lean toward quadrant boundaries, where the
        // CORDIC range folding and the clamping act.
        ang_list = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                     32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'h4000_0001, 32'h7FFF_FFFF};
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                it = make_request(scc_pkg::REQ_TO_CART, pick_value(),
                                  ($urandom_range(0, 4) == 0) ?
                                      ang_list[$urandom_range(0, 7)] : $urandom,
                                  ($urandom_range(0, 4) == 0) ?
                                      ang_list[$urandom_range(0, 7)] : $urandom);
            end
            else
            begin
                it = make_request(scc_pkg::REQ_TO_SPH, pick_value(), pick_value(),
                                  pick_value());
                if ($urandom_range(0, 9) == 0)
                begin
                    it.x = '0;
                    it.y = '0;
                end
            end
            send_request(it);
            // Once in the middle, hold off until every result is back.
            if (n == NUM_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        // A few more cycles to catch any stray result.
        settle = LATENCY + 20;
        repeat (settle)
            @(posedge clk);

        $display("Covered %0d spherical-to-cartesian requests (%0d saturated) and",
                 sb.n_cart, sb.n_sat);
        $display("%0d cartesian-to-spherical requests (%0d on the pole axis); %0d checked.",
                 sb.n_sph, sb.n_pole, sb.checked);
        if (sb.errors == 0)
            $display("PASS spherical_cartesian_converter");
        else
            $display("FAIL spherical_cartesian_converter");
        $finish;
    end

endmodule
